// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the pooling block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, off while reset is active.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, off while reset is active.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/mp2d_pkg.sv
// Constants and register codes of the 2-D max pooling block.
`timescale 1ns / 1ps
package mp2d_pkg;
	// Defaults for the top-level parameters
	localparam int DEF_MAX_KERNEL  = 4;
	localparam int DEF_MAX_WIDTH   = 256;
	localparam int DEF_SAMPLE_BITS = 16;

	// Configuration port
	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 3;

	// Field and register widths
	localparam int CH_BITS      = 11;
	localparam int CHAN_BITS    = 10;
	localparam int H_BITS       = 9;
	localparam int ROW_BITS     = 8;
	localparam int OUT_COL_BITS = 8;
	localparam int STRIDE_BITS  = 3;
	localparam int PHASE_BITS   = 2;

	// Register limits
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_STRIDE   = 4;

	// Reset values
	localparam int RST_CHANNELS = 1;
	localparam int RST_HEIGHT   = 8;
	localparam int RST_WIDTH    = 8;
	localparam int RST_KERNEL   = 2;
	localparam int RST_STRIDE   = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CHANNELS    = 3'd0,
		REG_HEIGHT      = 3'd1,
		REG_WIDTH       = 3'd2,
		REG_KERNEL_H    = 3'd3,
		REG_KERNEL_W    = 3'd4,
		REG_STRIDE_ROWS = 3'd5,
		REG_STRIDE_COLS = 3'd6
	} cfg_reg_t;
endpackage

// File: hdl/mp2d_in_if.sv
// Sample channel: valid/ready handshake carrying one input sample per word.
`timescale 1ns / 1ps
interface mp2d_in_if #(
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// File: hdl/mp2d_out_if.sv
// Result channel: valid/ready handshake carrying one pooled window per word.
`timescale 1ns / 1ps
interface mp2d_out_if #(
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
	import mp2d_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic [CHAN_BITS-1:0]          channel_index;
	logic [ROW_BITS-1:0]           out_row;
	logic [OUT_COL_BITS-1:0]       out_col;
	logic                          end_of_tensor;

	modport source (output valid, output max_value, output channel_index, output out_row,
		output out_col, output end_of_tensor, input ready);
	modport sink (input valid, input max_value, input channel_index, input out_row,
		input out_col, input end_of_tensor, output ready);
endinterface

// File: hdl/max_pool_2d_stream_top.sv
// Top level of the streaming 2-D max pooling block.
//
//  port     | dir | word carries
//  ---------+-----+--------------------------------------------------------------
//  in_ch    | in  | sample (channel, row, column raster order)
//  out_ch   | out | max_value, channel_index, out_row, out_col, end_of_tensor
//  cfg_*    | in  | register write: cfg_we, cfg_index, cfg_data (no read-back)
//
// One sample is taken per cycle while in_ch.ready is high. A window result leaves
// after the sample that completes it: the horizontal maximum and the line-store read are
// registered at the input, the vertical maximum is registered in the output stage.
// The line store has one bank per kernel row, each read once per word, written only on htrig.
// Reset clears counters and the row shift register; the line store is not cleared.
// A stalled output holds one result and one more in flight, then drops in_ch.ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module max_pool_2d_stream_top #(
	parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mp2d_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mp2d_pkg::CFG_BITS-1:0]     cfg_data,
	mp2d_in_if.sink                           in_ch,
	mp2d_out_if.source                        out_ch
);
	import mp2d_pkg::*;

	localparam int KB   = $clog2(MAX_KERNEL + 1);
	localparam int SLB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int WB   = $clog2(MAX_WIDTH + 1);
	localparam int XB   = $clog2(MAX_WIDTH);
	localparam int CW0  = (WB > KB) ? WB : KB;
	localparam int CMPW = ((CW0 > STRIDE_BITS) ? CW0 : STRIDE_BITS) + 1;
	localparam int RW0  = (H_BITS > KB) ? H_BITS : KB;
	localparam int RCW  = ((RW0 > STRIDE_BITS) ? RW0 : STRIDE_BITS) + 1;

	function automatic logic [31:0] clampv(input logic [CFG_BITS-1:0] v,
		input int unsigned lo, input int unsigned hi);
		logic [31:0] w;
		w = 32'(v);
		if (w < lo) return lo;
		if (w > hi) return hi;
		return w;
	endfunction

	// Configuration registers
	logic [CH_BITS-1:0]     ch_q;
	logic [H_BITS-1:0]      h_q;
	logic [WB-1:0]          w_q;
	logic [KB-1:0]          kh_q, kw_q;
	logic [STRIDE_BITS-1:0] sr_q, sc_q;
	logic                   wr_hit;

	// Position state
	logic [XB-1:0]         x_q;
	logic [ROW_BITS-1:0]   r_q;
	logic [CHAN_BITS-1:0]  c_q;
	logic [PHASE_BITS-1:0] ph_q, rph_q;
	logic [XB-1:0]         ocol_q;
	logic [ROW_BITS-1:0]   orow_q;
	logic [SLB-1:0]        slot_q;
	logic signed [SAMPLE_BITS-1:0] taps_q [MAX_KERNEL];

	// Decode of the incoming word
	logic acc, col_on, row_on, htrig, rtrig, otrig;
	logic last_col, last_row, last_chan, eot;
	logic signed [SAMPLE_BITS-1:0] hmax;

	// Stage 1
	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] hmax_s1;
	logic signed [SAMPLE_BITS-1:0] rd_s1 [MAX_KERNEL];
	logic [SLB-1:0]                slot_s1;
	logic [CHAN_BITS-1:0]          chan_s1;
	logic [ROW_BITS-1:0]           orow_s1;
	logic [OUT_COL_BITS-1:0]       ocol_s1;
	logic                          eot_s1;
	logic                          s1_adv;
	logic signed [SAMPLE_BITS-1:0] vmax;

	// Output register
	logic                          out_v_q;
	logic signed [SAMPLE_BITS-1:0] out_max_q;
	logic [CHAN_BITS-1:0]          out_chan_q;
	logic [ROW_BITS-1:0]           out_row_q;
	logic [OUT_COL_BITS-1:0]       out_col_q;
	logic                          out_eot_q;

	assign wr_hit = cfg_we && (cfg_index <= REG_STRIDE_COLS);

	// Write registers, clamped to their legal ranges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= CH_BITS'(RST_CHANNELS);
			h_q  <= H_BITS'(RST_HEIGHT);
			w_q  <= WB'(RST_WIDTH);
			kh_q <= KB'(RST_KERNEL);
			kw_q <= KB'(RST_KERNEL);
			sr_q <= STRIDE_BITS'(RST_STRIDE);
			sc_q <= STRIDE_BITS'(RST_STRIDE);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHANNELS:    ch_q <= CH_BITS'(clampv(cfg_data, 1, MAX_CHANNELS));
				REG_HEIGHT:      h_q  <= H_BITS'(clampv(cfg_data, 1, MAX_HEIGHT));
				REG_WIDTH:       w_q  <= WB'(clampv(cfg_data, 1, MAX_WIDTH));
				REG_KERNEL_H:    kh_q <= KB'(clampv(cfg_data, 1, MAX_KERNEL));
				REG_KERNEL_W:    kw_q <= KB'(clampv(cfg_data, 1, MAX_KERNEL));
				REG_STRIDE_ROWS: sr_q <= STRIDE_BITS'(clampv(cfg_data, 1, MAX_STRIDE));
				REG_STRIDE_COLS: sc_q <= STRIDE_BITS'(clampv(cfg_data, 1, MAX_STRIDE));
				default: ;
			endcase
		end
	end

	assign acc    = in_ch.valid && in_ch.ready;
	assign s1_adv = v_s1 && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !v_s1 || s1_adv;

	// Window triggers from the position counters
	assign col_on    = (CMPW'(x_q) + CMPW'(1)) >= CMPW'(kw_q);
	assign row_on    = (RCW'(r_q) + RCW'(1)) >= RCW'(kh_q);
	assign htrig     = col_on && (ph_q == '0);
	assign rtrig     = row_on && (rph_q == '0);
	assign otrig     = htrig && rtrig;
	assign last_col  = (CMPW'(x_q) + CMPW'(1)) >= CMPW'(w_q);
	assign last_row  = (RCW'(r_q) + RCW'(1)) >= RCW'(h_q);
	assign last_chan = (CH_BITS'(c_q) + CH_BITS'(1)) >= ch_q;
	assign eot = last_chan && ((CMPW'(x_q) + CMPW'(sc_q)) >= CMPW'(w_q))
		&& ((RCW'(r_q) + RCW'(sr_q)) >= RCW'(h_q));

	// Horizontal maximum over the new sample and the most recent taps
	always_comb begin
		hmax = in_ch.sample;
		for (int k = 1; k < MAX_KERNEL; k++) begin
			if ((k < int'(kw_q)) && (taps_q[k-1] > hmax)) hmax = taps_q[k-1];
		end
	end

	// Shift the row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_KERNEL; i++) taps_q[i] <= '0;
		end else if (acc) begin
			taps_q[0] <= in_ch.sample;
			for (int i = 1; i < MAX_KERNEL; i++) taps_q[i] <= taps_q[i-1];
		end
	end

	// Advance column, row and channel positions; a register write returns them to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			r_q    <= '0;
			c_q    <= '0;
			ph_q   <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			slot_q <= '0;
		end else if (wr_hit) begin
			x_q    <= '0;
			r_q    <= '0;
			c_q    <= '0;
			ph_q   <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				x_q    <= '0;
				ph_q   <= '0;
				ocol_q <= '0;
				if (last_row) begin
					r_q    <= '0;
					rph_q  <= '0;
					orow_q <= '0;
					slot_q <= '0;
					c_q    <= last_chan ? '0 : c_q + CHAN_BITS'(1);
				end else begin
					r_q <= r_q + ROW_BITS'(1);
					if (row_on) begin
						rph_q <= ({1'b0, rph_q} == sr_q - STRIDE_BITS'(1)) ? '0
							: rph_q + PHASE_BITS'(1);
					end
					if (rtrig) orow_q <= orow_q + ROW_BITS'(1);
					slot_q <= (slot_q == SLB'(MAX_KERNEL - 1)) ? '0 : slot_q + SLB'(1);
				end
			end else begin
				x_q <= x_q + XB'(1);
				if (col_on) begin
					ph_q <= ({1'b0, ph_q} == sc_q - STRIDE_BITS'(1)) ? '0
						: ph_q + PHASE_BITS'(1);
				end
				if (htrig) ocol_q <= ocol_q + XB'(1);
			end
		end
	end

	// Line store: one bank per kernel row slot, written and read at the output column
	for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
		logic signed [SAMPLE_BITS-1:0] hline_q [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (acc && htrig && (slot_q == SLB'(b))) hline_q[ocol_q] <= hmax;
			if (acc) rd_s1[b] <= hline_q[ocol_q];
		end
	end

	// Hold a pending window in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= otrig;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hmax_s1 <= hmax;
			slot_s1 <= slot_q;
			chan_s1 <= c_q;
			orow_s1 <= orow_q;
			ocol_s1 <= OUT_COL_BITS'(ocol_q);
			eot_s1  <= eot;
		end
	end

	// Vertical maximum over the earlier rows of the window
	always_comb begin
		int d;
		vmax = hmax_s1;
		for (int b = 0; b < MAX_KERNEL; b++) begin
			d = (int'(slot_s1) >= b) ? int'(slot_s1) - b : int'(slot_s1) + MAX_KERNEL - b;
			if ((d != 0) && (d < int'(kh_q)) && (rd_s1[b] > vmax)) vmax = rd_s1[b];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_max_q  <= vmax;
			out_chan_q <= chan_s1;
			out_row_q  <= orow_s1;
			out_col_q  <= ocol_s1;
			out_eot_q  <= eot_s1;
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.max_value     = out_max_q;
	assign out_ch.channel_index = out_chan_q;
	assign out_ch.out_row       = out_row_q;
	assign out_ch.out_col       = out_col_q;
	assign out_ch.end_of_tensor = out_eot_q;

	// Checks
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !in_ch.ready, v_s1 && out_v_q && !out_ch.ready)
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && out_v_q && !out_ch.ready, v_s1 && $stable(hmax_s1))
	`ASSERT_NEXT(a_row_wrap, clk, arst_n, acc && last_col && !wr_hit, x_q == '0)
	`ASSERT_IMPLIES(a_slot_range, clk, arst_n, 1'b1, slot_q <= SLB'(MAX_KERNEL - 1))
endmodule
